// ===== rtl/art_pkg.sv =====
// art_pkg: shared types, codes and helpers for the address reputation table.
// Used by art_cell, art_ctrl and address_reputation_table. No dependencies.
package art_pkg;

    localparam int ART_DEPTH_DEF = 64;
    localparam int ART_DEPTH_MAX = 1024;
    localparam int ART_IDX_W     = $clog2(ART_DEPTH_MAX);
    localparam int ART_CNT_W     = $clog2(ART_DEPTH_MAX + 1);

    localparam logic [15:0] ART_SCORE_MAX        = 16'hFFFF;
    localparam logic [9:0]  ART_STATUS_FORBIDDEN = 10'd403;
    localparam logic [9:0]  ART_STATUS_NOT_FOUND = 10'd404;

    localparam logic [7:0]  ART_RST_SCANNER = 8'd10;
    localparam logic [7:0]  ART_RST_ERROR   = 8'd1;
    localparam logic [31:0] ART_RST_TTL     = 32'd300000;
    localparam logic [6:0]  ART_RST_MAX     = 7'd64;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_SWEEP  = 2'd2
    } t_art_op;

    typedef enum logic [1:0] {
        CFG_SCANNER = 2'd0,
        CFG_ERROR   = 2'd1,
        CFG_TTL     = 2'd2,
        CFG_MAX     = 2'd3
    } t_art_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_art_state;

    // token that walks the cell chain, gathering search results
    typedef struct packed {
        logic                 vld;
        t_art_op              op;
        logic [31:0]          addr;
        logic [47:0]          now;
        logic [31:0]          ttl;
        logic                 found;
        logic [ART_IDX_W-1:0] found_idx;
        logic [15:0]          found_score;
        logic                 found_exp;
        logic [ART_CNT_W-1:0] count;
        logic                 old_vld;
        logic [ART_IDX_W-1:0] old_idx;
        logic [47:0]          old_seen;
        logic                 free_vld;
        logic [ART_IDX_W-1:0] free_idx;
        logic [ART_CNT_W-1:0] removed;
    } t_art_tok;

    // entry write and clear, broadcast to all cells
    typedef struct packed {
        logic                 wr_en;
        logic [ART_IDX_W-1:0] wr_idx;
        logic [31:0]          addr;
        logic [15:0]          score;
        logic [47:0]          seen;
        logic                 clr_en;
        logic [ART_IDX_W-1:0] clr_idx;
    } t_art_wr;

    function automatic logic [15:0] art_sat_add(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[16] ? ART_SCORE_MAX : s[15:0];
    endfunction

endpackage

// ===== rtl/art_cell.sv =====
// art_cell: one table entry plus one stage of the search token chain.
// Depends on art_pkg.
module art_cell import art_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_art_tok i_tok,
    input  t_art_wr  i_wr,
    output t_art_tok o_tok
);

    localparam logic [ART_IDX_W-1:0] L_IDX = ART_IDX_W'(CELL_IDX);

    logic        r_valid;
    logic [31:0] r_addr;
    logic [15:0] r_score;
    logic [47:0] r_seen;
    t_art_tok    r_tok;

    logic        n_valid;
    logic [31:0] n_addr;
    logic [15:0] n_score;
    logic [47:0] n_seen;
    t_art_tok    n_tok;

    logic        w_match;
    logic        w_exp;
    logic [47:0] w_age;

    assign w_match = r_valid && (r_addr == i_tok.addr);
    assign w_age   = i_tok.now - r_seen;
    assign w_exp   = (i_tok.now >= r_seen) && (w_age > {16'd0, i_tok.ttl});

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_addr  = r_addr;
        n_score = r_score;
        n_seen  = r_seen;
        if (i_tok.vld) begin
            case (i_tok.op)
                OP_RECORD: begin
                    if (w_match) begin
                        n_tok.found       = 1'b1;
                        n_tok.found_idx   = L_IDX;
                        n_tok.found_score = r_score;
                    end
                    if (r_valid) begin
                        n_tok.count = i_tok.count + ART_CNT_W'(1);
                        if (!i_tok.old_vld || (r_seen < i_tok.old_seen)) begin
                            n_tok.old_vld  = 1'b1;
                            n_tok.old_idx  = L_IDX;
                            n_tok.old_seen = r_seen;
                        end
                    end else if (!i_tok.free_vld) begin
                        n_tok.free_vld = 1'b1;
                        n_tok.free_idx = L_IDX;
                    end
                end
                OP_QUERY: begin
                    if (w_match) begin
                        n_tok.found       = 1'b1;
                        n_tok.found_score = r_score;
                        n_tok.found_exp   = w_exp;
                        if (w_exp) begin
                            n_valid = 1'b0;
                        end
                    end
                end
                OP_SWEEP: begin
                    if (r_valid && w_exp) begin
                        n_valid       = 1'b0;
                        n_tok.removed = i_tok.removed + ART_CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_wr.clr_en && (i_wr.clr_idx == L_IDX)) begin
            n_valid = 1'b0;
        end
        if (i_wr.wr_en && (i_wr.wr_idx == L_IDX)) begin
            n_valid = 1'b1;
            n_addr  = i_wr.addr;
            n_score = i_wr.score;
            n_seen  = i_wr.seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_score <= n_score;
        r_seen  <= n_seen;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/art_ctrl.sv =====
// art_ctrl: config registers, token launch, final decision and result register.
// Depends on art_pkg; drives the head of the art_cell chain.
module art_ctrl import art_pkg::*; #(
    parameter int TABLE_DEPTH = ART_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_now_ms,
    input  logic        i_scanner_hit,
    input  logic [9:0]  i_status_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_art_tok    o_tok,
    input  t_art_tok    i_tok,
    output t_art_wr     o_wr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_score_out,
    output logic        o_known,
    output logic        o_evicted,
    output logic [6:0]  o_removed_count
);

    localparam logic [ART_CNT_W-1:0] L_DEPTH = ART_CNT_W'(TABLE_DEPTH);

    t_art_state r_state, n_state;

    logic [7:0]  r_scanner;
    logic [7:0]  r_error;
    logic [31:0] r_ttl;
    logic [6:0]  r_max;

    t_art_tok r_launch, n_launch;
    t_art_tok r_cap;
    logic     r_hit;
    logic     r_err;

    logic        r_out_valid;
    logic [15:0] r_score;
    logic        r_known;
    logic        r_evicted;
    logic [6:0]  r_removed;

    logic                 w_accept;
    logic                 w_fin_go;
    logic [ART_CNT_W-1:0] w_max;
    logic [ART_CNT_W-1:0] w_limit;
    logic                 w_evict;
    logic [ART_IDX_W-1:0] w_slot;
    logic [15:0]          w_base;
    logic [15:0]          w_s1;
    logic [15:0]          w_s2;
    logic [15:0]          n_score;
    logic                 n_known;
    logic                 n_evicted;
    logic [6:0]           n_removed;

    assign w_accept = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept)  n_state = ST_SCAN;
            ST_SCAN: if (i_tok.vld) n_state = ST_FIN;
            ST_FIN:  if (w_fin_go)  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        w_fin_go = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready  = 1'b1;
            ST_SCAN: ;
            ST_FIN:  w_fin_go = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_comb begin
        n_launch           = '0;
        n_launch.vld       = w_accept;
        n_launch.op        = t_art_op'(i_op);
        n_launch.addr      = i_ip_addr;
        n_launch.now       = i_now_ms;
        n_launch.ttl       = r_ttl;
    end

    // decision on the gathered token
    assign w_max   = ART_CNT_W'(r_max);
    assign w_limit = (w_max == '0) ? ART_CNT_W'(1) : ((w_max > L_DEPTH) ? L_DEPTH : w_max);
    assign w_evict = !r_cap.found && (r_cap.count >= w_limit) && r_cap.old_vld;
    assign w_base  = r_cap.found ? r_cap.found_score : 16'd0;
    assign w_s1    = r_hit ? art_sat_add(w_base, r_scanner) : w_base;
    assign w_s2    = r_err ? art_sat_add(w_s1, r_error) : w_s1;

    always_comb begin
        if (r_cap.found) begin
            w_slot = r_cap.found_idx;
        end else if (w_evict) begin
            w_slot = (r_cap.free_vld && (r_cap.free_idx < r_cap.old_idx)) ?
                     r_cap.free_idx : r_cap.old_idx;
        end else begin
            w_slot = r_cap.free_idx;
        end
    end

    always_comb begin
        o_wr      = '0;
        n_score   = 16'd0;
        n_known   = 1'b0;
        n_evicted = 1'b0;
        n_removed = 7'd0;
        case (r_cap.op)
            OP_RECORD: begin
                o_wr.wr_en   = w_fin_go;
                o_wr.wr_idx  = w_slot;
                o_wr.addr    = r_cap.addr;
                o_wr.score   = w_s2;
                o_wr.seen    = r_cap.now;
                o_wr.clr_en  = w_fin_go && w_evict;
                o_wr.clr_idx = r_cap.old_idx;
                n_score      = w_s2;
                n_known      = r_cap.found;
                n_evicted    = w_evict;
            end
            OP_QUERY: begin
                n_known   = r_cap.found;
                n_evicted = r_cap.found && r_cap.found_exp;
                n_score   = (r_cap.found && !r_cap.found_exp) ? r_cap.found_score : 16'd0;
            end
            OP_SWEEP: begin
                n_removed = r_cap.removed[6:0];
                n_evicted = (r_cap.removed != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_launch.vld <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scanner    <= ART_RST_SCANNER;
            r_error      <= ART_RST_ERROR;
            r_ttl        <= ART_RST_TTL;
            r_max        <= ART_RST_MAX;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_art_cfg'(i_cfg_idx))
                    CFG_SCANNER: r_scanner <= i_cfg_data[7:0];
                    CFG_ERROR:   r_error   <= i_cfg_data[7:0];
                    CFG_TTL:     r_ttl     <= i_cfg_data;
                    CFG_MAX:     r_max     <= i_cfg_data[6:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit <= i_scanner_hit;
            r_err <= (i_status_code == ART_STATUS_FORBIDDEN) ||
                     (i_status_code == ART_STATUS_NOT_FOUND);
        end
        if ((r_state == ST_SCAN) && i_tok.vld) begin
            r_cap <= i_tok;
        end
        if (w_fin_go) begin
            r_score   <= n_score;
            r_known   <= n_known;
            r_evicted <= n_evicted;
            r_removed <= n_removed;
        end
    end

    assign o_tok           = r_launch;
    assign o_valid         = r_out_valid;
    assign o_score_out     = r_score;
    assign o_known         = r_known;
    assign o_evicted       = r_evicted;
    assign o_removed_count = r_removed;

endmodule

// ===== rtl/address_reputation_table.sv =====
// address_reputation_table: top level, controller plus a row of TABLE_DEPTH entry cells.
// Depends on art_pkg, art_cell and art_ctrl.
//
//   channel   signals                                              direction
//   request   i_valid/o_ready, i_op, i_ip_addr, i_now_ms,          in
//             i_scanner_hit, i_status_code
//   result    o_valid/i_ready, o_score_out, o_known, o_evicted,    out
//             o_removed_count
//   config    i_cfg_we, i_cfg_idx, i_cfg_data                      in
//
// o_valid rises after the request transfer once a search token, sent from the launch register,
// has walked the cell chain one entry per cycle; the controller captures it in a register and,
// in its final step, applies the table update and loads the result register.
// One request is in progress at a time; o_ready is high only between requests, so the
// next request is taken only once the result of the last one has been loaded.
// A result waiting on i_ready holds the block in its final step until taken.
// Synchronous active-low reset empties the table and loads the register defaults.
module address_reputation_table import art_pkg::*; #(
    parameter int TABLE_DEPTH = ART_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_now_ms,
    input  logic        i_scanner_hit,
    input  logic [9:0]  i_status_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_score_out,
    output logic        o_known,
    output logic        o_evicted,
    output logic [6:0]  o_removed_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_art_tok w_tok [0:TABLE_DEPTH];
    t_art_wr  w_wr;

    art_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_ip_addr       (i_ip_addr),
        .i_now_ms        (i_now_ms),
        .i_scanner_hit   (i_scanner_hit),
        .i_status_code   (i_status_code),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_tok           (w_tok[0]),
        .i_tok           (w_tok[TABLE_DEPTH]),
        .o_wr            (w_wr),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_score_out     (o_score_out),
        .o_known         (o_known),
        .o_evicted       (o_evicted),
        .o_removed_count (o_removed_count)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        art_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule
